// ----- rtl/core/rmq_pkg.sv -----
package rmq_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = 18;

   // Magnitude of one raw quaternion term (root argument or off-diagonal term).
   localparam int MAGW = ((FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W) + 2;
   localparam int VW   = MAGW + 1;
   localparam int SUMW = 2 * MAGW + 2;
   localparam int NRB  = SUMW / 2;
   localparam int NUMW = MAGW + FRAC_BITS + 1;
   localparam int QW   = FRAC_BITS + 1;
   localparam int CW   = ((QW > FIELD_W) ? QW : FIELD_W) + 1;

   localparam int REQ_W = ((9 * FIELD_W + 7) / 8) * 8;
   localparam int RSP_W = ((4 * FIELD_W + 7) / 8) * 8;

   localparam int ONE_INT     = 1 << FRAC_BITS;
   localparam int POS_MAX_INT = (1 << (FIELD_W - 1)) - 1;
   localparam int NEG_MAG_INT = 1 << (FIELD_W - 1);

   localparam logic [FIELD_W-1:0] W_DEG =
      FIELD_W'((ONE_INT > POS_MAX_INT) ? POS_MAX_INT : ONE_INT);
   localparam logic signed [VW-1:0] ONE_V = VW'(ONE_INT);
   localparam logic [CW-1:0] POS_MAX_C = CW'(POS_MAX_INT);
   localparam logic [CW-1:0] NEG_MAG_C = CW'(NEG_MAG_INT);

   typedef struct packed {
      logic [3:0]           neg;
      logic [3:0][MAGW-1:0] mag;
      logic                 degen;
   } vec_type;

   typedef struct packed {
      vec_type         vec;
      logic [SUMW-1:0] sum;
   } sq_type;

   typedef struct packed {
      vec_type        vec;
      logic [NRB-1:0] root;
   } root_type;

   typedef struct packed {
      logic [3:0][FIELD_W-1:0] quat;
      logic                    degen;
   } quat_type;

endpackage

// ----- rtl/core/rmq_front.sv -----
module rmq_front
   import rmq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [8:0][FIELD_W-1:0]    in_mat,
   output logic                       out_valid,
   input  logic                       out_ready,
   output sq_type                     out_data
);

   logic    v1_ff, v2_ff, v3_ff;
   logic    en1, en2, en3;
   vec_type vec1_ff, vec1_in;
   vec_type vec2_ff;
   logic [3:0][2*MAGW-1:0] sq2_ff, sq2_in;
   sq_type  d3_ff, d3_in;

   logic signed [VW-1:0] m [9];
   logic signed [VW-1:0] vv [4];
   logic signed [VW-1:0] trace, arg, a;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Branch select and raw vector; the vector (w, x, y, z), holding arg in the
   // chosen lane, points along the quaternion, so no root of arg is needed here.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m[i] = {{(VW-FIELD_W){in_mat[i][FIELD_W-1]}}, in_mat[i]};
      end
      trace = m[0] + m[4] + m[8];
      if (trace > 0) begin
         arg   = trace + ONE_V;
         vv[0] = arg;
         vv[1] = m[5] - m[7];
         vv[2] = m[6] - m[2];
         vv[3] = m[1] - m[3];
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         arg   = ONE_V + m[0] - m[4] - m[8];
         vv[0] = m[5] - m[7];
         vv[1] = arg;
         vv[2] = m[3] + m[1];
         vv[3] = m[6] + m[2];
      end else if (m[4] > m[8]) begin
         arg   = ONE_V + m[4] - m[0] - m[8];
         vv[0] = m[6] - m[2];
         vv[1] = m[3] + m[1];
         vv[2] = arg;
         vv[3] = m[7] + m[5];
      end else begin
         arg   = ONE_V + m[8] - m[0] - m[4];
         vv[0] = m[1] - m[3];
         vv[1] = m[6] + m[2];
         vv[2] = m[7] + m[5];
         vv[3] = arg;
      end
      vec1_in.degen = arg[VW-1] || (arg == '0);
      for (int i = 0; i < 4; i++) begin
         vec1_in.neg[i] = vv[i][VW-1];
         a = vv[i][VW-1] ? -vv[i] : vv[i];
         vec1_in.mag[i] = a[MAGW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq2_in[i] = vec1_ff.mag[i] * vec1_ff.mag[i];
      end
      d3_in.vec = vec2_ff;
      d3_in.sum = SUMW'(sq2_ff[0]) + SUMW'(sq2_ff[1]) + SUMW'(sq2_ff[2]) + SUMW'(sq2_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) vec1_ff <= vec1_in;
      if (en2) begin
         vec2_ff <= vec1_ff;
         sq2_ff  <= sq2_in;
      end
      if (en3) d3_ff <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

// ----- rtl/core/rmq_sqrt.sv -----
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  sq_type   in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output root_type out_data
);

   typedef struct packed {
      vec_type         vec;
      logic [SUMW-1:0] x;
      logic [SUMW-1:0] r;
   } sqst_type;

   logic     vld_ff [NRB];
   logic     en     [NRB];
   sqst_type st_ff  [NRB];
   sqst_type st_in  [NRB];

   always_comb begin
      for (int k = NRB - 1; k >= 0; k--) begin
         if (k == NRB - 1) en[k] = !vld_ff[k] || out_ready;
         else              en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // One result bit per stage, highest first.
   always_comb begin
      sqst_type   src;
      logic [SUMW:0] b, t;
      for (int k = 0; k < NRB; k++) begin
         if (k == 0) begin
            src.vec = in_data.vec;
            src.x   = in_data.sum;
            src.r   = '0;
         end else begin
            src = st_ff[k-1];
         end
         b = (SUMW+1)'(1) << (2 * (NRB - 1 - k));
         t = {1'b0, src.r} + b;
         st_in[k].vec = src.vec;
         if ({1'b0, src.x} >= t) begin
            st_in[k].x = src.x - t[SUMW-1:0];
            st_in[k].r = (src.r >> 1) + b[SUMW-1:0];
         end else begin
            st_in[k].x = src.x;
            st_in[k].r = src.r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NRB; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NRB; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NRB; k++) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

   assign out_valid     = vld_ff[NRB-1];
   assign out_data.vec  = st_ff[NRB-1].vec;
   assign out_data.root = st_ff[NRB-1].r[NRB-1:0];

endmodule

// ----- rtl/core/rmq_div.sv -----
module rmq_div
   import rmq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  root_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output quat_type out_data
);

   localparam int NS = QW + 1;

   typedef struct packed {
      logic [3:0]           neg;
      logic                 degen;
      logic [NRB-1:0]       n;
      logic [3:0][NUMW-1:0] rem;
      logic [3:0][QW-1:0]   q;
   } dst_type;

   logic     vld_ff [NS];
   logic     en     [NS];
   dst_type  st_ff  [NS];
   dst_type  st_in  [NS];
   logic     vo_ff, en_o;
   quat_type qo_ff, qo_in;

   assign en_o = !vo_ff || out_ready;
   always_comb begin
      for (int k = NS - 1; k >= 0; k--) begin
         if (k == NS - 1) en[k] = !vld_ff[k] || en_o;
         else             en[k] = !vld_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   // Stage 0 forms the rounded numerators; each later stage settles one
   // quotient bit of all four lanes.
   always_comb begin
      logic [NRB-1:0]  nn;
      logic [NUMW-1:0] d;
      dst_type         src;
      nn = (in_data.root == '0) ? NRB'(1) : in_data.root;
      st_in[0].neg   = in_data.vec.neg;
      st_in[0].degen = in_data.vec.degen;
      st_in[0].n     = nn;
      for (int i = 0; i < 4; i++) begin
         st_in[0].rem[i] = (NUMW'(in_data.vec.mag[i]) << FRAC_BITS) + NUMW'(nn >> 1);
         st_in[0].q[i]   = '0;
      end
      for (int k = 1; k < NS; k++) begin
         src = st_ff[k-1];
         st_in[k] = src;
         d = NUMW'(src.n) << (QW - k);
         for (int i = 0; i < 4; i++) begin
            if (src.rem[i] >= d) begin
               st_in[k].rem[i]       = src.rem[i] - d;
               st_in[k].q[i][QW - k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [CW-1:0] qe, sv;
      dst_type       src;
      src = st_ff[NS-1];
      qo_in.degen = src.degen;
      for (int i = 0; i < 4; i++) begin
         qe = CW'(src.q[i]);
         if (src.neg[i]) begin
            sv = (qe > NEG_MAG_C) ? NEG_MAG_C : qe;
            sv = -sv;
         end else begin
            sv = (qe > POS_MAX_C) ? POS_MAX_C : qe;
         end
         qo_in.quat[i] = sv[FIELD_W-1:0];
      end
      if (src.degen) begin
         qo_in.quat[0] = W_DEG;
         qo_in.quat[1] = '0;
         qo_in.quat[2] = '0;
         qo_in.quat[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) vld_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
         if (en_o) vo_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
      if (en_o) qo_ff <= qo_in;
   end

   assign out_valid = vo_ff;
   assign out_data  = qo_ff;

endmodule

// ----- rtl/core/rotation_matrix_to_quaternion_top.sv -----
// Rotation matrix to unit quaternion converter.
// The request channel carries one 3x3 matrix per transaction as nine signed
// Q2.16 words, column by column. The response channel returns the normalized
// quaternion (w, x, y, z) in the same format, and tuser marks a degenerate
// matrix for which the identity quaternion was returned.
// The block is a fully pipelined datapath: one transaction is accepted every
// cycle while the response channel is not stalled. It has 3 front stages
// for branch select, squares and sum, 21 stages of the bit-per-stage square
// root, and 19 stages for the numerator, the bit-per-stage divider and the
// output register.
// Every stage has its own valid bit and takes new data when it is empty or
// its successor moves, so bubbles close up and a stalled response holds its
// data while earlier stages keep filling. When rsp_tready stays low the
// pipeline fills and req_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; no transaction is in flight afterwards.
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // quat_w, quat_x, quat_y, quat_z
   output logic [RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic             rsp_tuser
);

   logic     f_valid, f_ready, s_valid, s_ready;
   sq_type   f_data;
   root_type s_data;
   quat_type q_data;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mat    (req_tdata[9*FIELD_W-1:0]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = RSP_W'(q_data.quat);
   assign rsp_tuser = q_data.degen;

   a_degen_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[FIELD_W-1:0] == W_DEG && rsp_tdata[4*FIELD_W-1:FIELD_W] == '0)
      else $error("degenerate result is not the identity");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         $signed(rsp_tdata[FIELD_W-1:0]) <= ONE_INT &&
         $signed(rsp_tdata[FIELD_W-1:0]) >= -ONE_INT &&
         $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) <= ONE_INT &&
         $signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) >= -ONE_INT)
      else $error("normalized component exceeds one");

endmodule
